// ----- rtl/core/cfs_pkg.sv -----
// Shared types and constants for the CSV field splitter.
// Holds the parser state, the result record and the byte and kind codes.
// No dependencies.
package cfs_pkg;

    // Fixed byte codes that the parser tests for or emits.
    localparam logic [7:0] BYTE_CR        = 8'd13;
    localparam logic [7:0] BYTE_LF        = 8'd10;
    localparam logic [7:0] BYTE_BACKSLASH = 8'd92;
    localparam logic [7:0] BYTE_N         = 8'd110;

    // Reset values of the configuration registers.
    localparam logic [7:0] SEPARATOR_RESET = 8'd44;
    localparam logic [7:0] QUOTE_RESET     = 8'd34;

    // Position count codes; the count saturates at the top value.
    localparam logic [1:0] POS_SECOND = 2'd2;
    localparam logic [1:0] POS_MAX    = 2'd3;

    // Configuration register indexes.
    localparam logic CFG_SEPARATOR = 1'b0;
    localparam logic CFG_QUOTE     = 1'b1;

    // Result kinds.
    typedef enum logic [2:0] {
        KIND_CHAR        = 3'd0,
        KIND_FIELD       = 3'd1,
        KIND_LINE        = 3'd2,
        KIND_FIELD_INPUT = 3'd3,
        KIND_INPUT       = 3'd4
    } kind_t;

    // Parser state carried from byte to byte.
    typedef struct packed {
        logic       at_field_start;
        logic       in_quoted;
        logic       pending_quote;
        logic [7:0] previous_byte;
        logic [1:0] position_count;
    } state_t;

    localparam state_t STATE_RESET = '{
        at_field_start: 1'b1,
        in_quoted:      1'b0,
        pending_quote:  1'b0,
        previous_byte:  8'd0,
        position_count: 2'd0
    };

    // Configuration seen by the decoder.
    typedef struct packed {
        logic [7:0] separator_char;
        logic [7:0] quote_char;
    } cfg_t;

    // One result item.
    typedef struct packed {
        logic [7:0] out_byte;
        kind_t      kind;
        logic       last;
    } result_t;

endpackage

// ----- rtl/core/csv_field_splitter.sv -----
// Top level of the CSV field splitter: configuration registers, parser
// state and the result queue. Depends on cfs_pkg, cfs_decode and
// cfs_result_queue.
//
// Usage: each input request carries one text byte or an end-of-input mark.
// The block strips the quotes of quoted fields and sends field characters
// and marks for field end, line end and input end on the result channel.
// A request may cause zero, one or two results; m_last flags the final one.
// The user sets separator and quote bytes through the write port only
// while idle; the block itself does not enforce this.
// A result is registered in the result queue before it is offered.
// Throughput: one request per cycle while each request gives at most one
// result and the receiver is ready; two results of one request leave the
// queue in turn. The four-entry result queue sets this: s_ready is high
// while at least two entries are free.
// Reset clears the parser state, empties the queue and loads comma and
// double quote. When the receiver stalls, results collect in the queue and
// s_ready drops once fewer than two entries are free.
module csv_field_splitter (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       s_end_of_input,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic [2:0] m_kind,
    output logic       m_last,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [7:0] cfg_wdata
);
    import cfs_pkg::*;

    cfg_t             cfg_reg;
    state_t           state_reg, state_next;
    logic [1:0]       res_count;
    result_t [1:0]    res;
    result_t          head;
    logic             accept;
    logic [1:0]       push_count;

    assign accept     = s_valid && s_ready;
    assign push_count = accept ? res_count : 2'd0;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.separator_char <= SEPARATOR_RESET;
            cfg_reg.quote_char     <= QUOTE_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_SEPARATOR: cfg_reg.separator_char <= cfg_wdata;
                CFG_QUOTE:     cfg_reg.quote_char     <= cfg_wdata;
                default:       cfg_reg                <= cfg_reg;
            endcase
        end
    end

    // Parser state advances on each accepted request.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= STATE_RESET;
        end else if (accept) begin
            state_reg <= state_next;
        end
    end

    cfs_decode u_decode (
        .state        (state_reg),
        .cfg          (cfg_reg),
        .in_byte      (s_in_byte),
        .end_of_input (s_end_of_input),
        .state_next   (state_next),
        .res_count    (res_count),
        .res          (res)
    );

    cfs_result_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_count (push_count),
        .push_data  (res),
        .has_room   (s_ready),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .head       (head)
    );

    assign m_out_byte = head.out_byte;
    assign m_kind     = head.kind;
    assign m_last     = head.last;

endmodule

// ----- rtl/core/cfs_decode.sv -----
// Per-byte decision logic of the CSV field splitter.
// Maps the current state, the configuration and one request to the next
// state and up to two results. Depends on cfs_pkg.
module cfs_decode (
    input  cfs_pkg::state_t       state,
    input  cfs_pkg::cfg_t         cfg,
    input  logic [7:0]            in_byte,
    input  logic                  end_of_input,
    output cfs_pkg::state_t       state_next,
    output logic [1:0]            res_count,
    output cfs_pkg::result_t [1:0] res
);
    import cfs_pkg::*;

    logic prev_is_quote;
    logic advance;

    assign prev_is_quote = (state.previous_byte == cfg.quote_char);

    // Classify the byte and decide on results and the next state.
    always_comb begin
        state_next = state;
        res_count  = 2'd0;
        res        = '0;
        advance    = 1'b1;

        if (!end_of_input && in_byte == cfg.quote_char) begin
            if (state.at_field_start) begin
                state_next.at_field_start = 1'b0;
                state_next.pending_quote  = 1'b0;
                state_next.in_quoted      = 1'b1;
            end else if (!state.in_quoted) begin
                res[0]    = '{cfg.quote_char, KIND_CHAR, 1'b0};
                res_count = 2'd1;
                state_next.pending_quote = 1'b0;
            end else if (prev_is_quote) begin
                if (state.pending_quote) begin
                    res[0]    = '{cfg.quote_char, KIND_CHAR, 1'b0};
                    res_count = 2'd1;
                    state_next.pending_quote = 1'b0;
                end else if (state.position_count != POS_SECOND) begin
                    state_next.pending_quote = 1'b1;
                end
            end
        end else if (!end_of_input && (in_byte == BYTE_CR || in_byte == BYTE_LF)) begin
            if (state.in_quoted && (!prev_is_quote || state.pending_quote)) begin
                res[0]    = '{in_byte, KIND_CHAR, 1'b0};
                res_count = 2'd1;
                state_next.pending_quote = 1'b0;
            end else if (state.position_count == POS_SECOND && prev_is_quote) begin
                // A line end after a quote in second place is spelled out.
                res[0]    = '{BYTE_BACKSLASH, KIND_CHAR, 1'b0};
                res[1]    = '{BYTE_N, KIND_CHAR, 1'b0};
                res_count = 2'd2;
                state_next.pending_quote = 1'b0;
            end else begin
                res[0]     = '{8'd0, KIND_LINE, 1'b0};
                res_count  = 2'd1;
                state_next = STATE_RESET;
                advance    = 1'b0;
            end
        end else if (end_of_input) begin
            if (state.at_field_start) begin
                res[0]    = '{8'd0, KIND_INPUT, 1'b0};
                res_count = 2'd1;
            end else if (state.in_quoted && state.pending_quote) begin
                res[0]    = '{cfg.quote_char, KIND_CHAR, 1'b0};
                res[1]    = '{8'd0, KIND_FIELD_INPUT, 1'b0};
                res_count = 2'd2;
            end else begin
                res[0]    = '{8'd0, KIND_FIELD_INPUT, 1'b0};
                res_count = 2'd1;
            end
            state_next = STATE_RESET;
            advance    = 1'b0;
        end else if (in_byte == cfg.separator_char) begin
            if (state.in_quoted && !(prev_is_quote && state.position_count == POS_MAX)) begin
                res[0]    = '{in_byte, KIND_CHAR, 1'b0};
                res_count = 2'd1;
            end else if (state.in_quoted && state.pending_quote) begin
                res[0]    = '{cfg.quote_char, KIND_CHAR, 1'b0};
                res[1]    = '{in_byte, KIND_CHAR, 1'b0};
                res_count = 2'd2;
            end else begin
                // Field end: back to a fresh field.
                res[0]    = '{8'd0, KIND_FIELD, 1'b0};
                res_count = 2'd1;
                state_next.at_field_start = 1'b1;
                state_next.in_quoted      = 1'b0;
                state_next.position_count = 2'd0;
            end
            state_next.pending_quote = 1'b0;
        end else begin
            if (state.pending_quote) begin
                res[0]    = '{cfg.quote_char, KIND_CHAR, 1'b0};
                res[1]    = '{in_byte, KIND_CHAR, 1'b0};
                res_count = 2'd2;
            end else begin
                res[0]    = '{in_byte, KIND_CHAR, 1'b0};
                res_count = 2'd1;
            end
            state_next.pending_quote  = 1'b0;
            state_next.at_field_start = 1'b0;
        end

        // Record the byte and bump the saturating position count.
        if (advance) begin
            state_next.previous_byte = in_byte;
            if (state_next.position_count != POS_MAX) begin
                state_next.position_count = state_next.position_count + 2'd1;
            end
        end

        // Flag the final result of this request.
        if (res_count == 2'd1) begin
            res[0].last = 1'b1;
        end else if (res_count == 2'd2) begin
            res[1].last = 1'b1;
        end
    end

endmodule

// ----- rtl/core/cfs_result_queue.sv -----
// Small result queue of the CSV field splitter.
// Takes up to two results per cycle and hands out one per cycle while the
// receiver is ready. Depends on cfs_pkg.
module cfs_result_queue (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic [1:0]             push_count,
    input  cfs_pkg::result_t [1:0] push_data,
    output logic                   has_room,
    output logic                   m_valid,
    input  logic                   m_ready,
    output cfs_pkg::result_t       head
);
    import cfs_pkg::*;

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    result_t            mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               pop;
    logic [PTR_W-1:0]   wr_ptr_plus1;

    // A new request may bring two results, so keep two slots free.
    assign has_room     = (count_reg <= CNT_W'(DEPTH - 2));
    assign m_valid      = (count_reg != '0);
    assign head         = mem_reg[rd_ptr_reg];
    assign pop          = m_valid && m_ready;
    assign wr_ptr_plus1 = wr_ptr_reg + PTR_W'(1);

    // Pointer and fill-level update.
    always_comb begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push_count);
        rd_ptr_next = pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push_count) - CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Result storage; payload needs no reset.
    always_ff @(posedge aclk) begin
        if (push_count != 2'd0) begin
            mem_reg[wr_ptr_reg] <= push_data[0];
        end
        if (push_count == 2'd2) begin
            mem_reg[wr_ptr_plus1] <= push_data[1];
        end
    end

endmodule

// ----- bench/tb_csv_field_splitter.sv -----
// Self-checking testbench for csv_field_splitter: a predictor of the parser
// runs beside the block and every result request is compared with it.
// Depends on cfs_pkg and the csv_field_splitter RTL.
module tb_csv_field_splitter;
    timeunit 1ns;
    timeprecision 1ps;

    import cfs_pkg::*;

    localparam int CYCLE_LIMIT = 800000;
    localparam int PHASE_ITEMS = 200;
    localparam int NUM_PHASES  = 8;
    localparam int SETTLE_CYCLES = 4;

    // One input request: a text byte or an end-of-input mark.
    typedef struct packed {
        logic [7:0] text_byte;
        logic       eoi;
    } request_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_in_byte = 8'd0;
    logic       s_end_of_input = 1'b0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_out_byte;
    logic [2:0] m_kind;
    logic       m_last;
    logic       cfg_we = 1'b0;
    logic       cfg_index = CFG_SEPARATOR;
    logic [7:0] cfg_wdata = 8'd0;

    // Predictor copy of the configuration and of the parser state.
    logic [7:0] sep_reg = SEPARATOR_RESET;
    logic [7:0] quote_reg = QUOTE_RESET;
    state_t     parse_state = STATE_RESET;

    request_t pending_requests[$];
    result_t  expected_tokens[$];
    result_t  step_tokens[$];
    int       queued_count = 0;
    int       mismatch_count = 0;
    int       cycle_count = 0;
    logic     send_gaps = 1'b1;
    logic     recv_stalls = 1'b1;

    csv_field_splitter u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_in_byte      (s_in_byte),
        .s_end_of_input (s_end_of_input),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_byte     (m_out_byte),
        .m_kind         (m_kind),
        .m_last         (m_last),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Idle lengths: mostly none or short, now and then long.
    function automatic int draw_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 95) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic void add_token(input logic [7:0] b, input kind_t k);
        result_t r;
        r.out_byte = b;
        r.kind = k;
        r.last = 1'b0;
        step_tokens = {step_tokens, r};
    endfunction

    // Parser predictor: advances the state by one request and queues the
    // tokens that the block should send for it.
    function automatic void parse_byte(input logic [7:0] c, input logic eoi);
        logic    prev_quote;
        logic    restart;
        prev_quote = (parse_state.previous_byte == quote_reg);
        restart = 1'b0;
        step_tokens.delete();
        if (!eoi && c == quote_reg) begin
            if (parse_state.at_field_start) begin
                parse_state.at_field_start = 1'b0;
                parse_state.pending_quote = 1'b0;
                parse_state.in_quoted = 1'b1;
            end else if (!parse_state.in_quoted) begin
                add_token(quote_reg, KIND_CHAR);
                parse_state.pending_quote = 1'b0;
            end else if (prev_quote) begin
                if (parse_state.pending_quote) begin
                    add_token(quote_reg, KIND_CHAR);
                    parse_state.pending_quote = 1'b0;
                end else if (parse_state.position_count != POS_SECOND) begin
                    parse_state.pending_quote = 1'b1;
                end
            end
        end else if (!eoi && (c == BYTE_CR || c == BYTE_LF)) begin
            if (parse_state.in_quoted && (!prev_quote || parse_state.pending_quote)) begin
                add_token(c, KIND_CHAR);
            end else if (parse_state.position_count == POS_SECOND && prev_quote) begin
                add_token(BYTE_BACKSLASH, KIND_CHAR);
                add_token(BYTE_N, KIND_CHAR);
            end else begin
                add_token(8'd0, KIND_LINE);
                restart = 1'b1;
            end
            parse_state.pending_quote = 1'b0;
        end else if (eoi) begin
            if (parse_state.at_field_start) begin
                add_token(8'd0, KIND_INPUT);
            end else begin
                if (parse_state.in_quoted && parse_state.pending_quote)
                    add_token(quote_reg, KIND_CHAR);
                add_token(8'd0, KIND_FIELD_INPUT);
            end
            restart = 1'b1;
        end else if (c == sep_reg) begin
            if (parse_state.in_quoted && !(prev_quote && parse_state.position_count > POS_SECOND)) begin
                add_token(c, KIND_CHAR);
            end else if (parse_state.in_quoted && parse_state.pending_quote) begin
                add_token(quote_reg, KIND_CHAR);
                add_token(c, KIND_CHAR);
            end else begin
                add_token(8'd0, KIND_FIELD);
                parse_state.at_field_start = 1'b1;
                parse_state.in_quoted = 1'b0;
                parse_state.position_count = 2'd0;
            end
            parse_state.pending_quote = 1'b0;
        end else begin
            if (parse_state.pending_quote)
                add_token(quote_reg, KIND_CHAR);
            add_token(c, KIND_CHAR);
            parse_state.pending_quote = 1'b0;
            parse_state.at_field_start = 1'b0;
        end

        if (restart) begin
            parse_state = STATE_RESET;
        end else begin
            parse_state.previous_byte = c;
            if (parse_state.position_count != POS_MAX)
                parse_state.position_count = parse_state.position_count + 2'd1;
        end

        if (step_tokens.size() > 0)
            step_tokens[step_tokens.size() - 1].last = 1'b1;
        expected_tokens = {expected_tokens, step_tokens};
    endfunction

    // Driver: presents queued requests, holding each until it is taken.
    always @(posedge aclk) begin
        request_t req;
        int       gap_left;
        if (!aresetn) begin
            s_valid <= 1'b0;
            gap_left = 0;
        end else begin
            if (s_valid && s_ready)
                parse_byte(s_in_byte, s_end_of_input);
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left = gap_left - 1;
                    s_valid <= 1'b0;
                end else if (pending_requests.size() > 0) begin
                    req = pending_requests.pop_front();
                    s_in_byte <= req.text_byte;
                    s_end_of_input <= req.eoi;
                    s_valid <= 1'b1;
                    gap_left = send_gaps ? draw_gap() : 0;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each result request against the oldest expected token.
    always @(posedge aclk) begin
        result_t want;
        int      stall_left;
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_tokens.size() == 0) begin
                    $display("%0t: unexpected result: byte %0d kind %0d last %0d",
                             $time, m_out_byte, m_kind, m_last);
                    mismatch_count++;
                end else begin
                    want = expected_tokens.pop_front();
                    if (m_out_byte !== want.out_byte) begin
                        $display("%0t: out_byte expected %0d, got %0d",
                                 $time, want.out_byte, m_out_byte);
                        mismatch_count++;
                    end
                    if (m_kind !== want.kind) begin
                        $display("%0t: kind expected %0d, got %0d", $time, want.kind, m_kind);
                        mismatch_count++;
                    end
                    if (m_last !== want.last) begin
                        $display("%0t: last expected %0d, got %0d", $time, want.last, m_last);
                        mismatch_count++;
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left = stall_left - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (recv_stalls && $urandom_range(0, 4) == 0)
                    stall_left = draw_gap();
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("** csv_field_splitter: FAILED **");
            $finish;
        end
    end

    task automatic push_byte(input logic [7:0] b);
        request_t req;
        req.text_byte = b;
        req.eoi = 1'b0;
        pending_requests = {pending_requests, req};
        queued_count++;
    endtask

    // End-of-input mark with a random byte that the block must ignore.
    task automatic push_eoi();
        request_t req;
        req.text_byte = 8'($urandom_range(0, 255));
        req.eoi = 1'b1;
        pending_requests = {pending_requests, req};
        queued_count++;
    endtask

    task automatic push_text(input string s);
        foreach (s[i])
            push_byte(s[i]);
    endtask

    // Field content: mostly plain bytes, with separators, line ends and quotes.
    task automatic push_content(input logic quoted);
        int count;
        count = $urandom_range(0, 5);
        repeat (count) begin
            case ($urandom_range(0, 9))
                5: push_byte(sep_reg);
                6: push_byte(BYTE_CR);
                7: push_byte(BYTE_LF);
                8: begin
                    push_byte(quote_reg);
                    if (quoted)
                        push_byte(quote_reg);
                end
                9: push_byte(8'($urandom_range(32, 126)));
                default: push_byte(8'($urandom_range(0, 255)));
            endcase
        end
    endtask

    // One CSV record of random content, or now and then a burst of noise.
    task automatic push_record();
        int fields;
        if ($urandom_range(0, 5) == 0) begin
            repeat ($urandom_range(1, 6)) begin
                case ($urandom_range(0, 5))
                    0: push_byte(sep_reg);
                    1: push_byte(quote_reg);
                    2: push_byte(BYTE_CR);
                    3: push_byte(BYTE_LF);
                    4: push_eoi();
                    default: push_byte(8'($urandom_range(0, 255)));
                endcase
            end
        end else begin
            fields = $urandom_range(1, 4);
            for (int f = 0; f < fields; f++) begin
                if (f > 0)
                    push_byte(sep_reg);
                if ($urandom_range(0, 1) == 1) begin
                    push_byte(quote_reg);
                    push_content(1'b1);
                    push_byte(quote_reg);
                end else begin
                    push_content(1'b0);
                end
            end
            case ($urandom_range(0, 9))
                0, 1, 2, 3: push_byte(BYTE_LF);
                4, 5, 6: begin
                    push_byte(BYTE_CR);
                    push_byte(BYTE_LF);
                end
                7, 8: push_byte(BYTE_CR);
                default: push_eoi();
            endcase
        end
    endtask

    // Wait until every request is taken and every token has arrived, then
    // let the block settle in case the last requests were quiet.
    task automatic drain();
        do
            @(negedge aclk);
        while (pending_requests.size() != 0 || s_valid || expected_tokens.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(input logic idx, input logic [7:0] value);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == CFG_SEPARATOR)
            sep_reg = value;
        else
            quote_reg = value;
    endtask

    initial begin
        logic [7:0] sep_set[NUM_PHASES];
        logic [7:0] quote_set[NUM_PHASES];
        int         phase_start;

        sep_set   = '{8'd44, 8'd0, 8'd255, BYTE_LF, 8'd7, 8'd0, 8'd0, 8'd59};
        quote_set = '{8'd34, 8'd255, 8'd0, BYTE_CR, 8'd7, 8'd0, 8'd0, 8'd39};
        sep_set[5]   = 8'($urandom_range(0, 255));
        quote_set[5] = 8'($urandom_range(0, 255));
        sep_set[6]   = 8'($urandom_range(0, 255));
        quote_set[6] = 8'($urandom_range(0, 255));

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part at the reset configuration.
        push_text("a,b");
        push_byte(BYTE_LF);
        // Quoted field with a doubled quote, then a separator after it.
        push_text("\"x\"\"y\",z");
        push_byte(BYTE_CR);
        // Line end right after a quote at the second position.
        push_text("a\"");
        push_byte(BYTE_CR);
        push_byte(BYTE_LF);
        // Extreme bytes, then an empty field at the end of input.
        push_byte(8'd0);
        push_byte(8'd255);
        push_byte(sep_reg);
        push_eoi();
        // Quoted field ending on a pending quote at the end of input.
        push_text("\"q\"\"");
        push_eoi();
        // Quote at the second position: switch the quote byte mid-field so
        // that the byte before it counts as a quote.
        push_text("\"x");
        drain();
        write_register(CFG_QUOTE, "x");
        push_text("x");
        push_eoi();
        drain();

        // Random records over several configurations, the extremes among them.
        for (int p = 0; p < NUM_PHASES; p++) begin
            write_register(CFG_SEPARATOR, sep_set[p]);
            write_register(CFG_QUOTE, quote_set[p]);
            send_gaps = ($urandom_range(0, 3) != 0);
            recv_stalls = ($urandom_range(0, 3) != 0);
            phase_start = queued_count;
            while (queued_count - phase_start < PHASE_ITEMS)
                push_record();
            drain();
        end

        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && expected_tokens.size() == 0)
            $display("** csv_field_splitter: PASSED **");
        else
            $display("** csv_field_splitter: FAILED **");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/cfs_pkg.sv
rtl/core/cfs_decode.sv
rtl/core/cfs_result_queue.sv
rtl/core/csv_field_splitter.sv
bench/tb_csv_field_splitter.sv
